// ----- rtl/ctes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctes_pkg: shared widths, constants and tables
// Field widths, calendar constants and the month offset table used by the
// civil time to epoch seconds pipeline.
// ----------------------------------------------------------------------------
package ctes_pkg;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int SECS_W  = 38;

    // Internal widths.
    localparam int YOFS_W  = 13;   // years since the epoch, up to 8029
    localparam int LEAP_W  = 11;   // leap days since the epoch, up to 1947
    localparam int DBM_W   = 9;    // days before the month, up to 335
    localparam int DAYS_W  = 22;   // days since the epoch, up to 2932896
    localparam int TOD_W   = 17;   // seconds of the day, up to 86399
    localparam int Q100_W  = 8;    // year / 100 for any 14-bit year

    // Calendar limits.
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 14'd1970;
    localparam logic [YEAR_W-1:0]  LAST_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] FEB        = 4'd2;
    localparam logic [MONTH_W-1:0] DEC        = 4'd12;
    localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;
    localparam logic [HOUR_W-1:0]  LAST_HOUR  = 5'd23;
    localparam logic [MIN_W-1:0]   LAST_MIN   = 6'd59;
    localparam logic [SEC_W-1:0]   LAST_SEC   = 6'd59;

    // Leap years in 1..1969: 492 - 19 + 4.
    localparam logic [YEAR_W-1:0]  LEAPS_BEFORE_EPOCH = 14'd477;

    // Division by 100 as multiply by 5243 and shift by 19; exact below 43690.
    localparam int                 DIV100_SHIFT = 19;
    localparam logic [12:0]        DIV100_MUL   = 13'd5243;
    localparam int                 PROD_W       = YEAR_W + 13;

    localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR = 22'd365;
    localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;
    localparam logic [TOD_W-1:0]   SECS_PER_DAY  = 17'd86400;

    // Days in the months before the given month of a common year.
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [DBM_W-1:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/ctes_day_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctes_day_count: three-stage day counter
// Turns year, month and day into whole days since 1970-01-01 with Gregorian
// leap years. Stage one forms the year / 100 products, stage two the leap
// day count, leap flag and month offset, stage three the final day sum.
// ----------------------------------------------------------------------------
module ctes_day_count (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic [ctes_pkg::YEAR_W-1:0]      i_year,
    input  logic [ctes_pkg::MONTH_W-1:0]     i_month,
    input  logic [ctes_pkg::DAY_W-1:0]       i_day,
    output logic                             o_vld,
    output logic [ctes_pkg::DAYS_W-1:0]      o_days
);

    // Valid bits, one per stage.
    logic [2:0] r_vld;
    logic [2:0] n_vld;

    // Stage one registers.
    logic [ctes_pkg::YEAR_W-1:0]  r1_yr;
    logic [ctes_pkg::MONTH_W-1:0] r1_mon;
    logic [ctes_pkg::DAY_W-1:0]   r1_day;
    logic [ctes_pkg::PROD_W-1:0]  r1_pm1;
    logic [ctes_pkg::PROD_W-1:0]  r1_p;
    logic [ctes_pkg::PROD_W-1:0]  n1_pm1;
    logic [ctes_pkg::PROD_W-1:0]  n1_p;

    // Stage two registers.
    logic [ctes_pkg::YOFS_W-1:0]  r2_yofs;
    logic [ctes_pkg::LEAP_W-1:0]  r2_leaps;
    logic [ctes_pkg::DBM_W-1:0]   r2_dbm;
    logic [ctes_pkg::DAY_W-1:0]   r2_day;
    logic [ctes_pkg::YOFS_W-1:0]  n2_yofs;
    logic [ctes_pkg::LEAP_W-1:0]  n2_leaps;
    logic [ctes_pkg::DBM_W-1:0]   n2_dbm;

    // Stage three register.
    logic [ctes_pkg::DAYS_W-1:0]  r3_days;
    logic [ctes_pkg::DAYS_W-1:0]  n3_days;

    // Stage two working values.
    logic [ctes_pkg::YEAR_W-1:0]  s2_ym1;
    logic [ctes_pkg::Q100_W-1:0]  s2_q100m1;
    logic [ctes_pkg::Q100_W-1:0]  s2_q100;
    logic [ctes_pkg::YEAR_W-1:0]  s2_leaps_full;
    logic [ctes_pkg::YEAR_W+1:0]  s2_cent;
    logic                         s2_leap;

    // The valid bits shift along with the data.
    assign n_vld = {r_vld[1:0], i_vld};

    // Stage one: reciprocal products for (year - 1) / 100 and year / 100.
    assign n1_pm1 = ctes_pkg::PROD_W'(i_year - 14'd1) * ctes_pkg::PROD_W'(ctes_pkg::DIV100_MUL);
    assign n1_p   = ctes_pkg::PROD_W'(i_year) * ctes_pkg::PROD_W'(ctes_pkg::DIV100_MUL);

    // Stage two: leap days in the whole years, leap flag and month offset.
    always_comb begin
        s2_ym1    = r1_yr - 14'd1;
        s2_q100m1 = r1_pm1[ctes_pkg::DIV100_SHIFT +: ctes_pkg::Q100_W];
        s2_q100   = r1_p[ctes_pkg::DIV100_SHIFT +: ctes_pkg::Q100_W];
        s2_leaps_full = {2'b00, s2_ym1[ctes_pkg::YEAR_W-1:2]}
                      - ctes_pkg::YEAR_W'(s2_q100m1)
                      + ctes_pkg::YEAR_W'(s2_q100m1[ctes_pkg::Q100_W-1:2])
                      - ctes_pkg::LEAPS_BEFORE_EPOCH;
        s2_cent   = 16'(s2_q100) * 16'd100;
        // Divisible by 4 and not a century, or a century divisible by 400.
        s2_leap   = (r1_yr[1:0] == 2'b00)
                 && ((s2_cent != 16'(r1_yr)) || (s2_q100[1:0] == 2'b00));
        n2_leaps  = s2_leaps_full[ctes_pkg::LEAP_W-1:0];
        n2_yofs   = ctes_pkg::YOFS_W'(r1_yr - ctes_pkg::EPOCH_YEAR);
        n2_dbm    = ctes_pkg::days_before_month(r1_mon)
                  + ctes_pkg::DBM_W'(s2_leap && (r1_mon > ctes_pkg::FEB));
    end

    // Stage three: days = 365 * years + leap days + month offset + day - 1.
    assign n3_days = ctes_pkg::DAYS_W'(r2_yofs) * ctes_pkg::DAYS_PER_YEAR
                   + ctes_pkg::DAYS_W'(r2_leaps)
                   + ctes_pkg::DAYS_W'(r2_dbm)
                   + ctes_pkg::DAYS_W'(r2_day)
                   - 22'd1;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r1_yr    <= i_year;
        r1_mon   <= i_month;
        r1_day   <= i_day;
        r1_pm1   <= n1_pm1;
        r1_p     <= n1_p;
        r2_yofs  <= n2_yofs;
        r2_leaps <= n2_leaps;
        r2_dbm   <= n2_dbm;
        r2_day   <= r1_day;
        r3_days  <= n3_days;
    end

    assign o_vld  = r_vld[2];
    assign o_days = r3_days;

endmodule

// ----- rtl/civil_time_to_epoch_seconds.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds: UTC date and time to epoch seconds
// Checks a broken-down date and time and gives the seconds since
// 1970-01-01 00:00:00 with Gregorian leap years. Out-of-range items give
// a cleared result with o_valid_res low.
//
// Channel   Direction  Transfer condition        Payload
// command   in         i_start && !o_busy        i_year .. i_second
// result    out        o_strobe (one cycle)      o_seconds, o_valid_res
//
// An item passes from its transfer to its result strobe through the day
// counter (three stages) and the final multiply by 86400 with the add of
// the time of day (one stage). A new item may be transferred in every
// cycle; o_busy stays low. Reset clears the valid bits only; results
// cannot be held off.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [ctes_pkg::YEAR_W-1:0]      i_year,
    input  logic [ctes_pkg::MONTH_W-1:0]     i_month,
    input  logic [ctes_pkg::DAY_W-1:0]       i_day,
    input  logic [ctes_pkg::HOUR_W-1:0]      i_hour,
    input  logic [ctes_pkg::MIN_W-1:0]       i_minute,
    input  logic [ctes_pkg::SEC_W-1:0]       i_second,
    output logic                             o_strobe,
    output logic [ctes_pkg::SECS_W-1:0]      o_seconds,
    output logic                             o_valid_res
);

    logic                                 s_ok;
    logic [ctes_pkg::TOD_W-1:0]           n_tod;
    logic                                 s_days_vld;
    logic [ctes_pkg::DAYS_W-1:0]          s_days;
    logic [ctes_pkg::DAYS_W+ctes_pkg::TOD_W-1:0] s_total;

    // Range flag and time of day, delayed to line up with the day count.
    logic [2:0]                           r_ok;
    logic [ctes_pkg::TOD_W-1:0]           r_tod [3];

    // Output registers.
    logic                                 r_strobe;
    logic                                 r_valid_res;
    logic [ctes_pkg::SECS_W-1:0]          r_seconds;
    logic [ctes_pkg::SECS_W-1:0]          n_seconds;

    // Every field is checked against its range.
    assign s_ok = (i_year >= ctes_pkg::EPOCH_YEAR) && (i_year <= ctes_pkg::LAST_YEAR)
               && (i_month != '0) && (i_month <= ctes_pkg::DEC)
               && (i_day != '0) && (i_day <= ctes_pkg::LAST_DAY)
               && (i_hour <= ctes_pkg::LAST_HOUR)
               && (i_minute <= ctes_pkg::LAST_MIN)
               && (i_second <= ctes_pkg::LAST_SEC);

    // Seconds within the day.
    assign n_tod = ctes_pkg::TOD_W'(i_hour) * ctes_pkg::SECS_PER_HOUR
                 + ctes_pkg::TOD_W'(i_minute) * ctes_pkg::SECS_PER_MIN
                 + ctes_pkg::TOD_W'(i_second);

    ctes_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_vld   (s_days_vld),
        .o_days  (s_days)
    );

    // Final stage: whole days in seconds plus the time of day.
    assign s_total   = (ctes_pkg::DAYS_W+ctes_pkg::TOD_W)'(s_days)
                     * (ctes_pkg::DAYS_W+ctes_pkg::TOD_W)'(ctes_pkg::SECS_PER_DAY)
                     + (ctes_pkg::DAYS_W+ctes_pkg::TOD_W)'(r_tod[2]);
    assign n_seconds = r_ok[2] ? s_total[ctes_pkg::SECS_W-1:0] : '0;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s_days_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ok        <= {r_ok[1:0], s_ok};
        r_tod[0]    <= n_tod;
        r_tod[1]    <= r_tod[0];
        r_tod[2]    <= r_tod[1];
        r_valid_res <= r_ok[2];
        r_seconds   <= n_seconds;
    end

    assign o_busy      = 1'b0;
    assign o_strobe    = r_strobe;
    assign o_seconds   = r_seconds;
    assign o_valid_res = r_valid_res;

`ifndef SYNTHESIS
    // A result strobe is traced back through the pipeline to its transfer.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, 4))
        else $error("result strobe without a transfer four cycles earlier");

    // A transfer is always answered by a result strobe.
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##4 o_strobe)
        else $error("transfer not answered by a result");

    // An out-of-range result carries zero seconds.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |-> (o_seconds == '0))
        else $error("invalid result with non-zero seconds");

    // Results never exceed 9999-12-31 23:59:59.
    a_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_seconds <= 38'd253402300799))
        else $error("seconds beyond the last representable instant");
`endif

endmodule

// ----- bench/civil_time_to_epoch_seconds_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds_tb: self-checking bench for the epoch converter
// Drives broken-down UTC dates and times into the converter and checks each
// result strobe against a calendar predictor held in the bench. A short table
// of directed items covers the field limits, every invalid field and the
// leap year and overlong day cases. It is followed by random items, most of
// them well-formed dates. Gaps between transfers are random, with steady
// stretches in which a new item is offered on every cycle.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds_tb;

    localparam int          NUM_ROWS     = 23;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // One broken-down date and time as it enters the converter.
    typedef struct packed {
        logic [ctes_pkg::YEAR_W-1:0]  year;
        logic [ctes_pkg::MONTH_W-1:0] month;
        logic [ctes_pkg::DAY_W-1:0]   day;
        logic [ctes_pkg::HOUR_W-1:0]  hour;
        logic [ctes_pkg::MIN_W-1:0]   minute;
        logic [ctes_pkg::SEC_W-1:0]   second;
    } t_civil_time;

    // One converted result.
    typedef struct packed {
        logic [ctes_pkg::SECS_W-1:0] seconds;
        logic                        valid;
    } t_epoch_result;

    // A directed row either carries its result or leaves it to the predictor.
    typedef struct packed {
        t_civil_time   stamp;
        logic          typed;
        t_epoch_result want;
    } t_stim_row;

    typedef enum int {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND
    } t_field_sel;

    localparam logic          FROM_TABLE     = 1'b1;
    localparam logic          FROM_PREDICTOR = 1'b0;
    localparam t_epoch_result RESULT_INVALID = '{seconds: '0, valid: 1'b0};
    localparam t_epoch_result RESULT_NONE    = '{seconds: '0, valid: 1'b0};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic [ctes_pkg::YEAR_W-1:0]   i_year;
    logic [ctes_pkg::MONTH_W-1:0]  i_month;
    logic [ctes_pkg::DAY_W-1:0]    i_day;
    logic [ctes_pkg::HOUR_W-1:0]   i_hour;
    logic [ctes_pkg::MIN_W-1:0]    i_minute;
    logic [ctes_pkg::SEC_W-1:0]    i_second;
    logic                          o_strobe;
    logic [ctes_pkg::SECS_W-1:0]   o_seconds;
    logic                          o_valid_res;

    t_epoch_result epoch_expect_q [$];
    t_epoch_result oldest_expect;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count    = 0;

    // Directed items: limits, each invalid field, leap years and overlong days.
    t_stim_row directed_rows [NUM_ROWS] = '{
        '{'{14'd1970,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  FROM_TABLE,
          '{38'd0, 1'b1}},
        '{'{14'd9999,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, FROM_TABLE,
          '{38'd253402300799, 1'b1}},
        '{'{14'd1969,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, FROM_TABLE, RESULT_INVALID},
        '{'{14'd10000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  FROM_TABLE, RESULT_INVALID},
        '{'{14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, FROM_TABLE, RESULT_INVALID},
        '{'{14'd0,     4'd0,  5'd0,  5'd0,  6'd0,  6'd0},  FROM_TABLE, RESULT_INVALID},
        '{'{14'd2000,  4'd0,  5'd10, 5'd12, 6'd0,  6'd0},  FROM_TABLE, RESULT_INVALID},
        '{'{14'd2000,  4'd13, 5'd10, 5'd12, 6'd0,  6'd0},  FROM_TABLE, RESULT_INVALID},
        '{'{14'd2000,  4'd6,  5'd0,  5'd12, 6'd0,  6'd0},  FROM_TABLE, RESULT_INVALID},
        '{'{14'd2000,  4'd6,  5'd15, 5'd24, 6'd0,  6'd0},  FROM_TABLE, RESULT_INVALID},
        '{'{14'd2000,  4'd6,  5'd15, 5'd12, 6'd60, 6'd0},  FROM_TABLE, RESULT_INVALID},
        '{'{14'd2000,  4'd6,  5'd15, 5'd12, 6'd30, 6'd60}, FROM_TABLE, RESULT_INVALID},
        '{'{14'd2000,  4'd2,  5'd29, 5'd12, 6'd0,  6'd0},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd2000,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd2100,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd2400,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd2023,  4'd2,  5'd31, 5'd6,  6'd7,  6'd8},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd2024,  4'd2,  5'd31, 5'd6,  6'd7,  6'd8},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd2038,  4'd1,  5'd19, 5'd3,  6'd14, 6'd7},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd1970,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd1971,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd9999,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  FROM_PREDICTOR, RESULT_NONE},
        '{'{14'd1972,  4'd2,  5'd29, 5'd0,  6'd0,  6'd1},  FROM_PREDICTOR, RESULT_NONE}
    };

    civil_time_to_epoch_seconds uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_year      (i_year),
        .i_month     (i_month),
        .i_day       (i_day),
        .i_hour      (i_hour),
        .i_minute    (i_minute),
        .i_second    (i_second),
        .o_strobe    (o_strobe),
        .o_seconds   (o_seconds),
        .o_valid_res (o_valid_res)
    );

    // Free-running clock with a 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Gregorian leap years in 1..n.
    function automatic longint unsigned leap_years_upto(input longint unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Seconds since the epoch for one item, or a cleared result if out of range.
    function automatic t_epoch_result predict_epoch(input t_civil_time t);
        t_epoch_result    r;
        longint unsigned  days;
        longint unsigned  month_base;
        bit               leap;
        r = RESULT_INVALID;
        if (t.year < ctes_pkg::EPOCH_YEAR || t.year > ctes_pkg::LAST_YEAR ||
            t.month < 4'd1 || t.month > ctes_pkg::DEC ||
            t.day < 5'd1 || t.day > ctes_pkg::LAST_DAY ||
            t.hour > ctes_pkg::LAST_HOUR || t.minute > ctes_pkg::LAST_MIN ||
            t.second > ctes_pkg::LAST_SEC) begin
            return r;
        end
        case (t.month)
            4'd1:    month_base = 0;
            4'd2:    month_base = 31;
            4'd3:    month_base = 59;
            4'd4:    month_base = 90;
            4'd5:    month_base = 120;
            4'd6:    month_base = 151;
            4'd7:    month_base = 181;
            4'd8:    month_base = 212;
            4'd9:    month_base = 243;
            4'd10:   month_base = 273;
            4'd11:   month_base = 304;
            default: month_base = 334;
        endcase
        leap = ((t.year % 4 == 0) && (t.year % 100 != 0)) || (t.year % 400 == 0);
        days = 64'd365 * (t.year - 64'd1970)
             + leap_years_upto(t.year - 64'd1) - leap_years_upto(64'd1969)
             + month_base + t.day - 64'd1;
        // February has 29 days in a leap year, so later months start a day on.
        if (t.month > ctes_pkg::FEB && leap) begin
            days = days + 1;
        end
        r.seconds = ctes_pkg::SECS_W'(days * 64'd86400 + t.hour * 64'd3600
                                      + t.minute * 64'd60 + t.second);
        r.valid   = 1'b1;
        return r;
    endfunction

    // A random item: mostly well-formed dates, some with one field out of
    // range, and some with every field drawn across its full width.
    function automatic t_civil_time random_stamp();
        t_civil_time t;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            t.year   = ctes_pkg::YEAR_W'($urandom_range(0, 16383));
            t.month  = ctes_pkg::MONTH_W'($urandom_range(0, 15));
            t.day    = ctes_pkg::DAY_W'($urandom_range(0, 31));
            t.hour   = ctes_pkg::HOUR_W'($urandom_range(0, 31));
            t.minute = ctes_pkg::MIN_W'($urandom_range(0, 63));
            t.second = ctes_pkg::SEC_W'($urandom_range(0, 63));
            return t;
        end
        // Century years exercise the divisible-by-100 and by-400 rules.
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            t.year = ctes_pkg::YEAR_W'(100 * $urandom_range(20, 99));
        end else if (roll < 30) begin
            t.year = $urandom_range(0, 1) ? ctes_pkg::EPOCH_YEAR : ctes_pkg::LAST_YEAR;
        end else begin
            t.year = ctes_pkg::YEAR_W'($urandom_range(1970, 9999));
        end
        t.month  = ctes_pkg::MONTH_W'($urandom_range(1, 12));
        t.day    = ctes_pkg::DAY_W'($urandom_range(1, 31));
        t.hour   = ctes_pkg::HOUR_W'($urandom_range(0, 23));
        t.minute = ctes_pkg::MIN_W'($urandom_range(0, 59));
        t.second = ctes_pkg::SEC_W'($urandom_range(0, 59));
        // A well-formed date spoiled in a single field.
        if ($urandom_range(0, 99) < 18) begin
            case (t_field_sel'($urandom_range(0, 5)))
                FLD_YEAR:   t.year   = $urandom_range(0, 1)
                                     ? ctes_pkg::YEAR_W'($urandom_range(0, 1969))
                                     : ctes_pkg::YEAR_W'($urandom_range(10000, 16383));
                FLD_MONTH:  t.month  = $urandom_range(0, 1)
                                     ? 4'd0
                                     : ctes_pkg::MONTH_W'($urandom_range(13, 15));
                FLD_DAY:    t.day    = 5'd0;
                FLD_HOUR:   t.hour   = ctes_pkg::HOUR_W'($urandom_range(24, 31));
                FLD_MINUTE: t.minute = ctes_pkg::MIN_W'($urandom_range(60, 63));
                default:    t.second = ctes_pkg::SEC_W'($urandom_range(60, 63));
            endcase
        end
        return t;
    endfunction

    // Idle cycles before the next transfer: mostly none or a few, rarely many.
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // Offers one item, waits for its transfer and records what it must give.
    task automatic send_item(input t_civil_time t, input logic typed,
                             input t_epoch_result want, input int unsigned gap);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start  <= 1'b1;
        i_year   <= t.year;
        i_month  <= t.month;
        i_day    <= t.day;
        i_hour   <= t.hour;
        i_minute <= t.minute;
        i_second <= t.second;
        do @(posedge i_clk); while (o_busy);
        epoch_expect_q.push_back(typed ? want : predict_epoch(t));
    endtask

    // Each result strobe is compared with the oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (epoch_expect_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual seconds %0d valid %0b",
                         $time, o_seconds, o_valid_res);
                mismatch_count <= mismatch_count + 1;
            end else begin
                oldest_expect = epoch_expect_q.pop_front();
                if (o_seconds !== oldest_expect.seconds ||
                    o_valid_res !== oldest_expect.valid) begin
                    $display({"%0t: result mismatch: expected seconds %0d valid %0b, ",
                              "actual seconds %0d valid %0b"},
                             $time, oldest_expect.seconds, oldest_expect.valid,
                             o_seconds, o_valid_res);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Reset, directed table, random items, then drain and report.
    initial begin
        i_rst_n  <= 1'b0;
        i_start  <= 1'b0;
        i_year   <= '0;
        i_month  <= '0;
        i_day    <= '0;
        i_hour   <= '0;
        i_minute <= '0;
        i_second <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_item(directed_rows[r].stamp, directed_rows[r].typed,
                      directed_rows[r].want, pick_gap(r < 8));
        end

        // Every fourth stretch of 150 items runs back to back.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_item(random_stamp(), FROM_PREDICTOR, RESULT_NONE,
                      pick_gap((n / 150) % 4 == 1));
        end
        // The last item has just been taken, so the command drops at once.
        i_start <= 1'b0;

        while (epoch_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && epoch_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
